/* rtl/dasp_pkg.sv */
// Shared constants and codes for the dual actuator position controller.
`timescale 1ns / 1ps
package dasp_pkg;

  localparam int unsigned STROKE_MM_DEF = 300;
  localparam int unsigned MIN_DRIVE_DEF = 60;

  localparam int unsigned BASE_LIMIT      = 200;
  localparam int unsigned DEADBAND        = 3;
  localparam int unsigned MANUAL_DEADZONE = 40;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POT_A_ZERO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POT_A_FULL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POT_B_ZERO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POT_B_FULL = 3'd7;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_MANUAL = 2'd2;

  localparam logic [7:0]  MAX_PWM_RST   = 8'd180;
  localparam logic [9:0]  POS_GAIN_RST  = 10'd128;
  localparam logic [9:0]  SYNC_GAIN_RST = 10'd77;
  localparam logic [11:0] RAMP_STEP_RST = 12'd112;
  localparam logic [9:0]  POT_ZERO_RST  = 10'd905;
  localparam logic [9:0]  POT_FULL_RST  = 10'd620;

endpackage

/* rtl/dual_actuator_sync_position_control.sv */
// Top level: sequenced controller built around one multiplier and one serial divider.
// Each pot mapping with a nonzero span adds a divider load, the divider iterations and an unload.
// A held tick maps two pots, a manual word two, a target word makes three mappings.
// An auto tick maps three pots and runs the loop.
// Throughput: one word at a time, taken in the idle cycle after the result is registered.
// Reset: asynchronous, active low; configuration registers return to their defaults, manual mode, no target.
`timescale 1ns / 1ps
module dual_actuator_sync_position_control #(
  parameter int unsigned STROKE_MM = dasp_pkg::STROKE_MM_DEF,
  parameter int unsigned MIN_DRIVE = dasp_pkg::MIN_DRIVE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dasp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dasp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [9:0]                     pot_a_i,
  input  logic [9:0]                     pot_b_i,
  input  logic [9:0]                     target_mm_i,
  input  logic signed [15:0]             manual_command_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     drive_a_fwd_o,
  output logic [7:0]                     drive_a_rev_o,
  output logic [7:0]                     drive_b_fwd_o,
  output logic [7:0]                     drive_b_rev_o,
  output logic signed [10:0]             position_mm_o,
  output logic                           manual_active_o
);
  import dasp_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MMA    = 4'd1;
  localparam logic [3:0] S_MMB    = 4'd2;
  localparam logic [3:0] S_TMM    = 4'd3;
  localparam logic [3:0] S_ERR    = 4'd4;
  localparam logic [3:0] S_BASE   = 4'd5;
  localparam logic [3:0] S_TRG    = 4'd6;
  localparam logic [3:0] S_CMD    = 4'd7;
  localparam logic [3:0] S_MAN    = 4'd8;
  localparam logic [3:0] S_CORR   = 4'd9;
  localparam logic [3:0] S_DRIVE  = 4'd10;
  localparam logic [3:0] S_DIVLD  = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_DIVEND = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  localparam logic [1:0] D_MMA = 2'd0;
  localparam logic [1:0] D_MMB = 2'd1;
  localparam logic [1:0] D_TMM = 2'd2;
  localparam logic [1:0] D_TRG = 2'd3;

  localparam logic signed [11:0] STROKE_S = 12'(STROKE_MM);
  localparam logic signed [28:0] MIN_P    = 29'(MIN_DRIVE);
  localparam logic signed [28:0] LIM_P    = 29'(BASE_LIMIT);
  localparam logic signed [28:0] DZ_P     = 29'(MANUAL_DEADZONE);
  localparam logic signed [11:0] DB_E     = 12'(DEADBAND);
  localparam logic [4:0]         DIV_LAST = 5'd19;

  // Configuration registers
  logic [7:0]  max_pwm_q;
  logic [9:0]  pos_gain_q, sync_gain_q;
  logic [11:0] ramp_step_q;
  logic [9:0]  za_q, fa_q, zb_q, fb_q;

  // Controller state
  logic [3:0]         state_q;
  logic [1:0]         kind_q;
  logic signed [15:0] cmd_q;
  logic [9:0]         tgt_q;
  logic [9:0]         pa_q, pb_q;
  logic signed [10:0] target_raw_q;
  logic               manual_q;
  logic signed [12:0] ramp_a_q, ramp_b_q;
  logic signed [8:0]  app_a_q, app_b_q;
  logic signed [10:0] mm_a_q, mm_b_q, tmm_q;
  logic signed [8:0]  base_q;
  logic               act_q;
  logic signed [28:0] prod_q;
  logic signed [10:0] den_q;
  logic [1:0]         dest_q;
  logic [10:0]        rem_q;
  logic [19:0]        quo_q;
  logic [9:0]         dvs_q;
  logic               neg_q;
  logic [4:0]         cnt_q;
  logic               ov_q;
  logic [7:0]         afwd_q, arev_q, bfwd_q, brev_q;
  logic signed [10:0] pos_q;
  logic               man_out_q;

  function automatic logic signed [28:0] trunc_shr(input logic signed [28:0] p,
                                                   input int k);
    logic [28:0] bias;
    bias = p[28] ? ((29'(1) << k) - 29'(1)) : '0;
    return $signed(p + bias) >>> k;
  endfunction

  function automatic logic signed [10:0] sat_mm(input logic signed [20:0] q);
    if (q < -21'sd1024) return -11'sd1024;
    if (q > 21'sd1023) return 11'sd1023;
    return q[10:0];
  endfunction

  function automatic logic signed [12:0] ramp_f(input logic signed [12:0] cur,
                                                input logic signed [12:0] tgt,
                                                input logic [11:0] stp);
    logic signed [13:0] up, dn, t14;
    up  = {cur[12], cur} + $signed({2'b00, stp});
    dn  = {cur[12], cur} - $signed({2'b00, stp});
    t14 = {tgt[12], tgt};
    if (cur < tgt) return (up > t14) ? tgt : up[12:0];
    if (cur > tgt) return (dn < t14) ? tgt : dn[12:0];
    return cur;
  endfunction

  function automatic logic signed [8:0] ramp_to_duty(input logic signed [12:0] cur);
    logic signed [12:0] s;
    s = $signed(cur + (cur[12] ? 13'd15 : 13'd0)) >>> 4;
    return s[8:0];
  endfunction

  function automatic logic signed [8:0] demand(input logic signed [8:0] base,
                                               input logic signed [28:0] corr,
                                               input logic [7:0] mx, input logic a);
    logic signed [28:0] v, m;
    v = 29'(base) + corr;
    m = $signed({21'b0, mx});
    if (!a) return '0;
    if (v < -m) return -$signed({1'b0, mx});
    if (v > m) return $signed({1'b0, mx});
    return v[8:0];
  endfunction

  // Shared multiplier operand selection
  logic signed [16:0] mul_a;
  logic signed [11:0] mul_b;
  logic signed [28:0] mul_p;
  logic signed [10:0] den_sel;
  logic signed [11:0] mm_sum, avg12, err;
  logic signed [10:0] pdiff_a, pdiff_b, pdiff_t, span_a, span_b;
  logic [9:0]         tgt_sat;

  assign pdiff_a = $signed({1'b0, pa_q}) - $signed({1'b0, za_q});
  assign pdiff_b = $signed({1'b0, pb_q}) - $signed({1'b0, zb_q});
  assign pdiff_t = target_raw_q - $signed({1'b0, za_q});
  assign span_a  = $signed({1'b0, fa_q}) - $signed({1'b0, za_q});
  assign span_b  = $signed({1'b0, fb_q}) - $signed({1'b0, zb_q});
  assign tgt_sat = ({2'b0, tgt_q} > 12'(STROKE_MM)) ? 10'(STROKE_MM) : tgt_q;
  assign mm_sum  = 12'(mm_a_q) + 12'(mm_b_q);
  assign avg12   = $signed(mm_sum + 12'(mm_sum[11])) >>> 1;
  assign err     = 12'(tmm_q) - avg12;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    den_sel = '0;
    case (state_q)
      S_MMA: begin
        mul_a = 17'(pdiff_a); mul_b = STROKE_S; den_sel = span_a;
      end
      S_MMB: begin
        mul_a = 17'(pdiff_b); mul_b = STROKE_S; den_sel = span_b;
      end
      S_TMM: begin
        mul_a = 17'(pdiff_t); mul_b = STROKE_S; den_sel = span_a;
      end
      S_ERR: begin
        mul_a = 17'(err); mul_b = $signed({2'b00, pos_gain_q});
      end
      S_TRG: begin
        mul_a = $signed({7'b0, tgt_sat}); mul_b = 12'(span_a); den_sel = STROKE_S[10:0];
      end
      S_CMD: begin
        mul_a = 17'(cmd_q); mul_b = $signed({4'b0, max_pwm_q});
      end
      S_CORR: begin
        mul_a = 17'(12'(mm_a_q) - 12'(mm_b_q)); mul_b = $signed({2'b00, sync_gain_q});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Where to go once both actuator heights are known
  logic [3:0] after_mm;
  always_comb begin
    case (kind_q)
      KIND_TICK:   after_mm = (!manual_q && !target_raw_q[10]) ? S_TMM : S_OUT;
      KIND_TARGET: after_mm = S_TRG;
      KIND_MANUAL: after_mm = S_CMD;
      default:     after_mm = S_OUT;
    endcase
  end

  // Divider step and result
  logic [10:0]        div_sh;
  logic               div_ge;
  logic signed [20:0] quot;
  logic signed [28:0] p16, p32k, pcorr, pmag;
  logic signed [8:0]  ta, tb, sa, sb;
  logic signed [12:0] ra_n, rb_n;
  logic signed [8:0]  neg_a, neg_b;

  assign div_sh = {rem_q[9:0], quo_q[19]};
  assign div_ge = div_sh >= {1'b0, dvs_q};
  assign quot   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign p16    = trunc_shr(prod_q, 4);
  assign p32k   = trunc_shr(prod_q, 15);
  assign pcorr  = trunc_shr(prod_q, 8);
  assign pmag   = prod_q[28] ? -prod_q : prod_q;

  assign ta   = demand(base_q, -pcorr, max_pwm_q, act_q);
  assign tb   = demand(base_q, pcorr, max_pwm_q, act_q);
  assign ra_n = ramp_f(ramp_a_q, {ta, 4'b0}, ramp_step_q);
  assign rb_n = ramp_f(ramp_b_q, {tb, 4'b0}, ramp_step_q);

  // Soft travel limits; motor B keeps the reversed sense.
  always_comb begin
    sa = ramp_to_duty(ra_n);
    sb = ramp_to_duty(rb_n);
    if (pa_q > za_q && sa < 0) sa = '0;
    if (pa_q < fa_q && sa > 0) sa = '0;
    if (pb_q > zb_q && sb > 0) sb = '0;
    if (pb_q < fb_q && sb < 0) sb = '0;
  end

  assign neg_a = -app_a_q;
  assign neg_b = -app_b_q;

  logic out_load;
  assign out_load   = (state_q == S_OUT) && (!ov_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pwm_q    <= MAX_PWM_RST;
      pos_gain_q   <= POS_GAIN_RST;
      sync_gain_q  <= SYNC_GAIN_RST;
      ramp_step_q  <= RAMP_STEP_RST;
      za_q         <= POT_ZERO_RST;
      fa_q         <= POT_FULL_RST;
      zb_q         <= POT_ZERO_RST;
      fb_q         <= POT_FULL_RST;
      state_q      <= S_IDLE;
      pa_q         <= '0;
      pb_q         <= '0;
      target_raw_q <= -11'sd1;
      manual_q     <= 1'b1;
      ramp_a_q     <= '0;
      ramp_b_q     <= '0;
      app_a_q      <= '0;
      app_b_q      <= '0;
      ov_q         <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_PWM:    max_pwm_q   <= cfg_data_i[7:0];
          REG_POS_GAIN:   pos_gain_q  <= cfg_data_i[9:0];
          REG_SYNC_GAIN:  sync_gain_q <= cfg_data_i[9:0];
          REG_RAMP_STEP:  ramp_step_q <= cfg_data_i;
          REG_POT_A_ZERO: za_q        <= cfg_data_i[9:0];
          REG_POT_A_FULL: fa_q        <= cfg_data_i[9:0];
          REG_POT_B_ZERO: zb_q        <= cfg_data_i[9:0];
          REG_POT_B_FULL: fb_q        <= cfg_data_i[9:0];
          default: ;
        endcase
      end

      if (ov_q && out_ready_i && !out_load) ov_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (kind_i == KIND_TICK) begin
              pa_q <= pot_a_i;
              pb_q <= pot_b_i;
            end
            state_q <= S_MMA;
          end
        end
        S_MMA, S_MMB, S_TMM: begin
          prod_q <= mul_p;
          den_q  <= den_sel;
          if (den_sel == '0) begin
            if (state_q == S_MMA) begin
              mm_a_q <= '0; state_q <= S_MMB;
            end else if (state_q == S_MMB) begin
              mm_b_q <= '0; state_q <= after_mm;
            end else begin
              tmm_q <= '0; state_q <= S_ERR;
            end
          end else begin
            dest_q  <= (state_q == S_MMA) ? D_MMA : (state_q == S_MMB) ? D_MMB : D_TMM;
            state_q <= S_DIVLD;
          end
        end
        S_TRG: begin
          prod_q  <= mul_p;
          den_q   <= den_sel;
          dest_q  <= D_TRG;
          state_q <= S_DIVLD;
        end
        S_DIVLD: begin
          quo_q   <= pmag[19:0];
          dvs_q   <= den_q[10] ? 10'(-den_q) : den_q[9:0];
          neg_q   <= prod_q[28] ^ den_q[10];
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= div_ge ? (div_sh - {1'b0, dvs_q}) : div_sh;
          quo_q <= {quo_q[18:0], div_ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == DIV_LAST) state_q <= S_DIVEND;
        end
        S_DIVEND: begin
          case (dest_q)
            D_MMA: begin
              mm_a_q <= sat_mm(quot); state_q <= S_MMB;
            end
            D_MMB: begin
              mm_b_q <= sat_mm(quot); state_q <= after_mm;
            end
            D_TMM: begin
              tmm_q <= sat_mm(quot); state_q <= S_ERR;
            end
            default: begin
              target_raw_q <= quot[10:0] + $signed({1'b0, za_q});
              manual_q     <= 1'b0;
              state_q      <= S_OUT;
            end
          endcase
        end
        S_ERR: begin
          prod_q  <= mul_p;
          act_q   <= (err >= DB_E) || (err <= -DB_E);
          state_q <= S_BASE;
        end
        S_BASE: begin
          // A scaled drive of zero falls on the negative side.
          if (p16 > 0) begin
            base_q <= (p16 < MIN_P) ? MIN_P[8:0] : (p16 > LIM_P) ? LIM_P[8:0] : p16[8:0];
          end else begin
            base_q <= (p16 < -LIM_P) ? 9'(-LIM_P) : (p16 > -MIN_P) ? 9'(-MIN_P) : p16[8:0];
          end
          state_q <= S_CORR;
        end
        S_CMD: begin
          prod_q  <= mul_p;
          state_q <= S_MAN;
        end
        S_MAN: begin
          act_q        <= (p32k >= DZ_P) || (p32k <= -DZ_P);
          base_q       <= (p32k < -LIM_P) ? 9'(-LIM_P) : (p32k > LIM_P) ? LIM_P[8:0] : p32k[8:0];
          manual_q     <= 1'b1;
          target_raw_q <= -11'sd1;
          state_q      <= S_CORR;
        end
        S_CORR: begin
          prod_q  <= mul_p;
          state_q <= S_DRIVE;
        end
        S_DRIVE: begin
          ramp_a_q <= ra_n;
          ramp_b_q <= rb_n;
          app_a_q  <= sa;
          app_b_q  <= sb;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            afwd_q    <= (app_a_q > 0) ? app_a_q[7:0] : 8'd0;
            arev_q    <= (app_a_q < 0) ? neg_a[7:0] : 8'd0;
            bfwd_q    <= (app_b_q > 0) ? app_b_q[7:0] : 8'd0;
            brev_q    <= (app_b_q < 0) ? neg_b[7:0] : 8'd0;
            pos_q     <= avg12[10:0];
            man_out_q <= manual_q;
            ov_q      <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      cmd_q  <= manual_command_i;
      tgt_q  <= target_mm_i;
    end
  end

  assign out_valid_o     = ov_q;
  assign drive_a_fwd_o   = afwd_q;
  assign drive_a_rev_o   = arev_q;
  assign drive_b_fwd_o   = bfwd_q;
  assign drive_b_rev_o   = brev_q;
  assign position_mm_o   = pos_q;
  assign manual_active_o = man_out_q;

`ifndef NO_ASSERTIONS
  a_manual_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    manual_q |-> target_raw_q == -11'sd1)
    else $error("manual mode with a target set");
  a_duty_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !((afwd_q != 8'd0 && arev_q != 8'd0) || (bfwd_q != 8'd0 && brev_q != 8'd0)))
    else $error("both duty sides driven");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> dvs_q != 10'd0)
    else $error("divider running with a zero divisor");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("word accepted while busy");
`endif

endmodule
